// ----- hw/rtl/dphd_pkg.sv -----
// ----------------------------------------------------------------------------
// dphd_pkg
// Types, register codes and constants shared by the drum pad hit detector.
// ----------------------------------------------------------------------------
`default_nettype none

package dphd_pkg;

    localparam int LVL_W     = 7;            // threshold, full scale, note, velocity
    localparam int MS_W      = 8;            // phase lengths in ms
    localparam int US_LEN_W  = 18;           // phase length in us, 255 * 1000 fits
    localparam int SMP_W     = 10;
    localparam int TS_W      = 32;           // width of the timestamp field
    localparam int PEAK_W    = 8;            // level 0..128
    localparam int NUM_W     = 2 * LVL_W;    // (peak - thr) * 127
    localparam int DIV_STEPS = LVL_W;        // one quotient bit per step
    localparam int CNT_W     = $clog2(DIV_STEPS);
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 8;

    localparam logic [LVL_W-1:0] VEL_MAX = 7'd127;

    localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FULL_SCALE = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_NOTE       = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SCAN_MS    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_MASK_MS    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_RETRIG_MS  = 3'd5;

    localparam logic [LVL_W-1:0] RST_THRESHOLD  = 7'd20;
    localparam logic [LVL_W-1:0] RST_FULL_SCALE = 7'd100;
    localparam logic [LVL_W-1:0] RST_NOTE       = 7'd38;
    localparam logic [MS_W-1:0]  RST_SCAN_MS    = 8'd3;
    localparam logic [MS_W-1:0]  RST_MASK_MS    = 8'd50;
    localparam logic [MS_W-1:0]  RST_RETRIG_MS  = 8'd10;

    typedef enum logic [1:0] {
        PH_IDLE   = 2'd0,
        PH_SCAN   = 2'd1,
        PH_MASK   = 2'd2,
        PH_RETRIG = 2'd3
    } t_phase;

    typedef enum logic [1:0] {
        SQ_IDLE = 2'd0,
        SQ_EVAL = 2'd1,
        SQ_DIV  = 2'd2,
        SQ_EMIT = 2'd3
    } t_seq;

    typedef struct packed {
        logic             start;
        logic [NUM_W-1:0] num;
        logic [LVL_W-1:0] den;
    } t_div_req;

    typedef struct packed {
        logic             busy;
        logic             done;
        logic [LVL_W-1:0] quot;
    } t_div_rsp;

    // ms * 1000 as ms * 1024 - ms * 16 - ms * 8
    function automatic logic [US_LEN_W-1:0] ms_to_us(input logic [MS_W-1:0] ms);
        logic [US_LEN_W-1:0] m;
        m = US_LEN_W'(ms);
        return (m << 10) - (m << 4) - (m << 3);
    endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/dphd_div.sv -----
// ----------------------------------------------------------------------------
// dphd_div
// Restoring divider, one quotient bit per cycle. The caller guarantees the
// quotient fits in LVL_W bits (num < den * 2^LVL_W).
// ----------------------------------------------------------------------------
`default_nettype none

module dphd_div (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire dphd_pkg::t_div_req i_req,
    output dphd_pkg::t_div_rsp      o_rsp
);
    import dphd_pkg::*;

    logic             r_busy, n_busy;
    logic             r_done, n_done;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic [LVL_W-1:0] r_rem, n_rem;
    logic [LVL_W-1:0] r_bits, n_bits;
    logic [LVL_W-1:0] r_quot, n_quot;
    logic [LVL_W-1:0] r_den, n_den;

    logic [LVL_W:0]   trial;
    logic [LVL_W:0]   diff;
    logic             ge;

    always_comb begin
        trial  = {r_rem, r_bits[LVL_W-1]};
        diff   = trial - {1'b0, r_den};
        ge     = trial >= {1'b0, r_den};
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_rem  = r_rem;
        n_bits = r_bits;
        n_quot = r_quot;
        n_den  = r_den;
        if (i_req.start) begin
            n_busy = 1'b1;
            n_cnt  = '0;
            n_rem  = i_req.num[NUM_W-1:LVL_W];
            n_bits = i_req.num[LVL_W-1:0];
            n_den  = i_req.den;
        end else if (r_busy) begin
            n_rem  = ge ? diff[LVL_W-1:0] : trial[LVL_W-1:0];
            n_bits = {r_bits[LVL_W-2:0], 1'b0};
            n_quot = {r_quot[LVL_W-2:0], ge};
            n_cnt  = r_cnt + 1'b1;
            if (r_cnt == CNT_W'(DIV_STEPS - 1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rem  <= n_rem;
        r_bits <= n_bits;
        r_quot <= n_quot;
        r_den  <= n_den;
    end

    assign o_rsp.busy = r_busy;
    assign o_rsp.done = r_done;
    assign o_rsp.quot = r_quot;

    a_no_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req.start |-> !r_busy)
        else $error("divider started while busy");

    a_rem_below_den: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> (r_rem < r_den))
        else $error("partial remainder not below divisor");

    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> !r_busy)
        else $error("divider done while still busy");

endmodule

`default_nettype wire

// ----- hw/rtl/drum_pad_hit_detector.sv -----
// ----------------------------------------------------------------------------
// drum_pad_hit_detector
// Piezo trigger: level detect, peak scan, velocity scaling, mask/retrigger.
// ----------------------------------------------------------------------------
// Input channel (i_in_valid / o_in_stall) takes one word: a signed sample and
// a microsecond timestamp. Output channel (o_out_valid / i_out_stall) gives a
// note event at the end of each scan window. Config writes come on
// i_cfg_valid / o_cfg_ready (always ready), index 0..5, others ignored.
// Timing: a word is taken, evaluated in the next cycle, and the block is
// ready again in the cycle after that if the word ends no scan. A word
// that ends a scan runs the divider, one quotient bit per cycle, then
// the result goes to the output register when it is empty or being taken.
// A peak or full scale not above threshold skips the divider.
// The output register holds one event; a new word is taken while it waits,
// and a further event is held back until the receiver takes the first.
// Reset (synchronous, active low) restores register defaults, idle phase
// and an empty output.
// ----------------------------------------------------------------------------
`default_nettype none

module drum_pad_hit_detector #(
    parameter int TIME_BITS = 32
) (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_rst_n,
    input  wire logic                                  i_in_valid,
    output logic                                       o_in_stall,
    input  wire logic signed [dphd_pkg::SMP_W-1:0]     i_sample,
    input  wire logic [dphd_pkg::TS_W-1:0]             i_time_us,
    output logic                                       o_out_valid,
    input  wire logic                                  i_out_stall,
    output logic [dphd_pkg::LVL_W-1:0]                 o_hit_note,
    output logic [dphd_pkg::LVL_W-1:0]                 o_hit_velocity,
    input  wire logic                                  i_cfg_valid,
    output logic                                       o_cfg_ready,
    input  wire logic [dphd_pkg::CFG_IDX_W-1:0]        i_cfg_index,
    input  wire logic [dphd_pkg::CFG_DAT_W-1:0]        i_cfg_data
);
    import dphd_pkg::*;

    localparam int CMP_W = (TIME_BITS > US_LEN_W) ? TIME_BITS : US_LEN_W;

    // configuration
    logic [LVL_W-1:0] r_thr, r_fs, r_note;
    logic [MS_W-1:0]  r_scan_ms, r_mask_ms, r_retrig_ms;

    // sequencer and detector state
    t_seq                r_seq, n_seq;
    t_phase              r_phase, n_phase;
    logic [PEAK_W-1:0]   r_peak, n_peak;
    logic [TIME_BITS-1:0] r_start, n_start;
    logic [US_LEN_W-1:0] r_len, n_len;
    logic [PEAK_W-1:0]   r_level;
    logic [TIME_BITS-1:0] r_now;
    logic [LVL_W-1:0]    r_ev_note, n_ev_note;
    logic [LVL_W-1:0]    r_ev_vel, n_ev_vel;
    logic                r_out_valid, n_out_valid;
    logic [LVL_W-1:0]    r_out_note, r_out_vel;

    logic                 accept;
    logic                 out_load;
    logic [SMP_W-1:0]     mag;
    logic [TIME_BITS-1:0] now_in;
    logic [TIME_BITS-1:0] elapsed;
    logic                 over;
    logic [PEAK_W-1:0]    peak_upd;
    logic [LVL_W-1:0]     pk_clamp;
    logic [LVL_W-1:0]     vel_diff;
    t_div_req             div_req;
    t_div_rsp             div_rsp;

    generate
        if (TIME_BITS > TS_W) begin : g_time_wide
            assign now_in = {{(TIME_BITS - TS_W){1'b0}}, i_time_us};
        end else if (TIME_BITS == TS_W) begin : g_time_same
            assign now_in = i_time_us;
        end else begin : g_time_narrow
            assign now_in = i_time_us[TIME_BITS-1:0];
        end
    endgenerate

    // -512 negates to 512, which reads correctly as unsigned
    assign mag = i_sample[SMP_W-1] ? (SMP_W'(0) - SMP_W'(i_sample)) : SMP_W'(i_sample);

    assign accept      = i_in_valid && !o_in_stall;
    assign o_in_stall  = (r_seq != SQ_IDLE);
    assign o_cfg_ready = 1'b1;
    assign out_load    = (r_seq == SQ_EMIT) && (!r_out_valid || !i_out_stall);

    assign elapsed  = r_now - r_start;
    assign over     = CMP_W'(elapsed) > CMP_W'(r_len);
    assign peak_upd = (r_level > r_peak) ? r_level : r_peak;
    assign pk_clamp = (peak_upd > {1'b0, r_fs}) ? r_fs : peak_upd[LVL_W-1:0];
    assign vel_diff = pk_clamp - r_thr;

    always_comb begin
        n_seq       = r_seq;
        n_phase     = r_phase;
        n_peak      = r_peak;
        n_start     = r_start;
        n_len       = r_len;
        n_ev_note   = r_ev_note;
        n_ev_vel    = r_ev_vel;
        n_out_valid = r_out_valid && i_out_stall;
        div_req.start = 1'b0;
        div_req.num   = (NUM_W'(vel_diff) << LVL_W) - NUM_W'(vel_diff);
        div_req.den   = r_fs - r_thr;
        case (r_seq)
            SQ_IDLE: begin
                if (accept) begin
                    n_seq = SQ_EVAL;
                end
            end
            SQ_EVAL: begin
                n_seq = SQ_IDLE;
                case (r_phase)
                    PH_IDLE: begin
                        if (r_level > {1'b0, r_thr}) begin
                            n_peak  = r_level;
                            n_phase = PH_SCAN;
                            n_start = r_now;
                            n_len   = ms_to_us(r_scan_ms);
                        end
                    end
                    PH_SCAN: begin
                        n_peak = peak_upd;
                        if (over) begin
                            n_ev_note = r_note;
                            n_phase   = PH_MASK;
                            n_start   = r_now;
                            n_len     = ms_to_us(r_mask_ms);
                            if (r_fs <= r_thr) begin
                                n_ev_vel = VEL_MAX;
                                n_seq    = SQ_EMIT;
                            end else if (pk_clamp <= r_thr) begin
                                n_ev_vel = '0;
                                n_seq    = SQ_EMIT;
                            end else begin
                                div_req.start = 1'b1;
                                n_seq         = SQ_DIV;
                            end
                        end
                    end
                    PH_MASK: begin
                        if (over) begin
                            n_phase = PH_RETRIG;
                            n_start = r_now;
                            n_len   = ms_to_us(r_retrig_ms);
                        end
                    end
                    default: begin
                        if (over) begin
                            n_phase = PH_IDLE;
                        end
                    end
                endcase
            end
            SQ_DIV: begin
                if (div_rsp.done) begin
                    n_ev_vel = div_rsp.quot;
                    n_seq    = SQ_EMIT;
                end
            end
            default: begin
                if (out_load) begin
                    n_out_valid = 1'b1;
                    n_seq       = SQ_IDLE;
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seq       <= SQ_IDLE;
            r_phase     <= PH_IDLE;
            r_peak      <= '0;
            r_start     <= '0;
            r_len       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_seq       <= n_seq;
            r_phase     <= n_phase;
            r_peak      <= n_peak;
            r_start     <= n_start;
            r_len       <= n_len;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_level <= mag[SMP_W-1:2];
            r_now   <= now_in;
        end
        r_ev_note <= n_ev_note;
        r_ev_vel  <= n_ev_vel;
        if (out_load) begin
            r_out_note <= r_ev_note;
            r_out_vel  <= r_ev_vel;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr       <= RST_THRESHOLD;
            r_fs        <= RST_FULL_SCALE;
            r_note      <= RST_NOTE;
            r_scan_ms   <= RST_SCAN_MS;
            r_mask_ms   <= RST_MASK_MS;
            r_retrig_ms <= RST_RETRIG_MS;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_THRESHOLD:  r_thr       <= i_cfg_data[LVL_W-1:0];
                CFG_FULL_SCALE: r_fs        <= i_cfg_data[LVL_W-1:0];
                CFG_NOTE:       r_note      <= i_cfg_data[LVL_W-1:0];
                CFG_SCAN_MS:    r_scan_ms   <= i_cfg_data;
                CFG_MASK_MS:    r_mask_ms   <= i_cfg_data;
                CFG_RETRIG_MS:  r_retrig_ms <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    dphd_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    assign o_out_valid    = r_out_valid;
    assign o_hit_note     = r_out_note;
    assign o_hit_velocity = r_out_vel;

    a_div_running: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_seq == SQ_DIV) |-> (div_rsp.busy || div_rsp.done))
        else $error("waiting on divider that is not running");

    a_div_to_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_rst_n && r_seq == SQ_DIV && div_rsp.done) |=> (r_seq == SQ_EMIT))
        else $error("divider result not passed to output");

    a_phase_only_eval: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_rst_n && r_seq != SQ_EVAL) |=> $stable(r_phase))
        else $error("phase changed outside evaluation");

endmodule

`default_nettype wire

// ----- verif/drum_pad_hit_detector_tb.sv -----
// ----------------------------------------------------------------------------
// drum_pad_hit_detector_tb
// Self-checking bench for the drum pad hit detector. A behavioural model of
// the pad (rectified level, peak scan, mask and retrigger timing, velocity
// scaling) predicts each note event when its word is taken. A sink process
// compares every event with the oldest prediction. Directed words hit the
// threshold and timing edges and the register extremes. A backpressure run
// fills the block. Random runs then replay whole hit sequences under
// changing settings and random gaps on both channels.
// ----------------------------------------------------------------------------
module drum_pad_hit_detector_tb;

    timeunit 1ns;
    timeprecision 1ps;

    import dphd_pkg::*;

    localparam int SETTLE_CYCLES = 16;      // worst word through the divider
    localparam int RANDOM_WORDS  = 700;
    localparam int WORDS_PER_RUN = 70;

    typedef struct packed {
        logic [LVL_W-1:0] note;
        logic [LVL_W-1:0] velocity;
    } t_pad_hit;

    logic                     i_clk;
    logic                     i_rst_n = 1'b0;
    logic                     i_in_valid = 1'b0;
    logic                     o_in_stall;
    logic signed [SMP_W-1:0]  i_sample = '0;
    logic [TS_W-1:0]          i_time_us = '0;
    logic                     o_out_valid;
    logic                     i_out_stall = 1'b0;
    logic [LVL_W-1:0]         o_hit_note;
    logic [LVL_W-1:0]         o_hit_velocity;
    logic                     i_cfg_valid = 1'b0;
    logic                     o_cfg_ready;
    logic [CFG_IDX_W-1:0]     i_cfg_index = '0;
    logic [CFG_DAT_W-1:0]     i_cfg_data = '0;

    // pad model: registers and phase state
    logic [LVL_W-1:0]     reg_threshold  = RST_THRESHOLD;
    logic [LVL_W-1:0]     reg_full_scale = RST_FULL_SCALE;
    logic [LVL_W-1:0]     reg_note       = RST_NOTE;
    logic [MS_W-1:0]      reg_scan_ms    = RST_SCAN_MS;
    logic [MS_W-1:0]      reg_mask_ms    = RST_MASK_MS;
    logic [MS_W-1:0]      reg_retrig_ms  = RST_RETRIG_MS;
    t_phase               pad_phase      = PH_IDLE;
    logic [PEAK_W-1:0]    pad_peak       = '0;
    logic [TS_W-1:0]      pad_start_us   = '0;
    logic [US_LEN_W-1:0]  pad_len_us     = '0;

    t_pad_hit expected_hits[$];
    int       mismatch_count = 0;
    int       words_sent = 0;
    bit       tx_idle_on = 1'b1;
    bit       rx_idle_on = 1'b1;
    int       rx_hold_cycles = 0;
    logic [TS_W-1:0] now_us = '0;

    drum_pad_hit_detector u_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_sample       (i_sample),
        .i_time_us      (i_time_us),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_hit_note     (o_hit_note),
        .o_hit_velocity (o_hit_velocity),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #10_000_000;
        $display("drum_pad_hit_detector_tb: errors");
        $finish;
    end

    // ------------------------------------------------------------------------
    // pad model
    // ------------------------------------------------------------------------
    function automatic logic [LVL_W-1:0] velocity_for(input int thr, input int fs,
                                                      input int pk);
        if (fs <= thr) return VEL_MAX;
        if (pk > fs) pk = fs;
        if (pk <= thr) return '0;
        return LVL_W'((pk - thr) * int'(VEL_MAX) / (fs - thr));
    endfunction

    task automatic start_phase(input t_phase nxt, input logic [TS_W-1:0] now,
                               input logic [MS_W-1:0] ms);
        pad_phase    = nxt;
        pad_start_us = now;
        pad_len_us   = US_LEN_W'(int'(ms) * 1000);
    endtask

    task automatic track_pad_hit(input logic [SMP_W-1:0] smp, input logic [TS_W-1:0] now);
        int               mag;
        logic [PEAK_W-1:0] lvl;
        logic [TS_W-1:0]  elapsed;
        logic             over;
        t_pad_hit         hit;
        mag = smp[SMP_W-1] ? (1 << SMP_W) - int'(smp) : int'(smp);
        lvl = PEAK_W'(mag >> 2);
        elapsed = now - pad_start_us;
        over = elapsed > TS_W'(pad_len_us);
        case (pad_phase)
            PH_IDLE: begin
                if (lvl > PEAK_W'(reg_threshold)) begin
                    pad_peak = lvl;
                    start_phase(PH_SCAN, now, reg_scan_ms);
                end
            end
            PH_SCAN: begin
                if (lvl > pad_peak) pad_peak = lvl;
                if (over) begin
                    hit.note     = reg_note;
                    hit.velocity = velocity_for(int'(reg_threshold), int'(reg_full_scale),
                                                int'(pad_peak));
                    expected_hits.push_back(hit);
                    start_phase(PH_MASK, now, reg_mask_ms);
                end
            end
            PH_MASK: begin
                if (over) start_phase(PH_RETRIG, now, reg_retrig_ms);
            end
            default: begin
                if (over) pad_phase = PH_IDLE;
            end
        endcase
    endtask

    // ------------------------------------------------------------------------
    // channel drivers
    // ------------------------------------------------------------------------
    task automatic log_mismatch(input string what);
        mismatch_count++;
        if (mismatch_count <= 10) $display("mismatch: %s", what);
    endtask

    // valid is left high after the word is taken when no gap follows; the
    // next call or settle_pad decides what happens to it
    task automatic send_word(input logic [SMP_W-1:0] smp, input logic [TS_W-1:0] ts);
        int gap;
        i_in_valid <= 1'b1;
        i_sample   <= smp;
        i_time_us  <= ts;
        do @(posedge i_clk); while (o_in_stall);
        track_pad_hit(smp, ts);
        gap = tx_idle_on ? $urandom_range(0, 19) : 0;
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic settle_pad();
        i_in_valid <= 1'b0;
        while (expected_hits.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DAT_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            CFG_THRESHOLD:  reg_threshold  = data[LVL_W-1:0];
            CFG_FULL_SCALE: reg_full_scale = data[LVL_W-1:0];
            CFG_NOTE:       reg_note       = data[LVL_W-1:0];
            CFG_SCAN_MS:    reg_scan_ms    = data;
            CFG_MASK_MS:    reg_mask_ms    = data;
            CFG_RETRIG_MS:  reg_retrig_ms  = data;
            default: ;
        endcase
    endtask

    // all six registers plus one write to an unused index
    task automatic load_config(input logic [CFG_DAT_W-1:0] thr, input logic [CFG_DAT_W-1:0] fs,
                               input logic [CFG_DAT_W-1:0] note,
                               input logic [CFG_DAT_W-1:0] scan_ms,
                               input logic [CFG_DAT_W-1:0] mask_ms,
                               input logic [CFG_DAT_W-1:0] retrig_ms);
        write_reg(CFG_THRESHOLD, thr);
        write_reg(CFG_FULL_SCALE, fs);
        write_reg(CFG_NOTE, note);
        write_reg(CFG_SCAN_MS, scan_ms);
        write_reg(CFG_MASK_MS, mask_ms);
        write_reg(CFG_RETRIG_MS, retrig_ms);
        write_reg(CFG_IDX_W'($urandom_range(6, 7)), CFG_DAT_W'($urandom));
        i_cfg_valid <= 1'b0;
    endtask

    // ------------------------------------------------------------------------
    // event sink
    // ------------------------------------------------------------------------
    initial begin : hit_sink
        int       hold;
        t_pad_hit want;
        do @(posedge i_clk); while (!i_rst_n);
        forever begin
            hold = rx_idle_on ? $urandom_range(0, 19) : 0;
            if (rx_hold_cycles > 0) begin
                hold = rx_hold_cycles;
                rx_hold_cycles = 0;
            end
            if (hold > 0) begin
                i_out_stall <= 1'b1;
                repeat (hold) @(posedge i_clk);
                i_out_stall <= 1'b0;
            end
            do @(posedge i_clk); while (!o_out_valid);
            if (expected_hits.size() == 0) begin
                log_mismatch($sformatf("unexpected event note=%0d velocity=%0d",
                                       o_hit_note, o_hit_velocity));
            end else begin
                want = expected_hits.pop_front();
                if (o_hit_note !== want.note)
                    log_mismatch($sformatf("note exp=%0d got=%0d", want.note, o_hit_note));
                if (o_hit_velocity !== want.velocity)
                    log_mismatch($sformatf("velocity exp=%0d got=%0d",
                                           want.velocity, o_hit_velocity));
            end
        end
    end

    // ------------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------------
    function automatic logic [SMP_W-1:0] pick_sample();
        int r;
        r = $urandom_range(0, 99);
        if (r < 5)  return {1'b1, {(SMP_W-1){1'b0}}};     // most negative
        if (r < 10) return {1'b0, {(SMP_W-1){1'b1}}};     // most positive
        if (r < 14) return '0;
        if (r < 18) return '1;
        return SMP_W'($urandom);
    endfunction

    // mostly steps well inside the current phase, some exactly on its end or one past it,
    // some jumps anywhere (backwards and across the wrap)
    function automatic logic [TS_W-1:0] pick_time(input logic [TS_W-1:0] cur);
        int              r;
        logic [TS_W-1:0] phase_end;
        r = $urandom_range(0, 99);
        phase_end = pad_start_us + TS_W'(pad_len_us);
        if (r < 8)  return phase_end;
        if (r < 16) return phase_end + 1;
        if (r < 19) return TS_W'($urandom);
        return cur + TS_W'($urandom_range(0, int'(pad_len_us) / 2 + 2));
    endfunction

    function automatic logic [CFG_DAT_W-1:0] pick_level();
        int               r;
        logic [LVL_W-1:0] v;
        r = $urandom_range(0, 99);
        if (r < 15)      v = '0;
        else if (r < 30) v = '1;
        else             v = LVL_W'($urandom_range(0, 70));
        return {1'($urandom_range(0, 1)), v};
    endfunction

    function automatic logic [CFG_DAT_W-1:0] pick_ms();
        int r;
        r = $urandom_range(0, 99);
        if (r < 10) return '1;
        if (r < 30) return '0;
        return CFG_DAT_W'($urandom_range(1, 6));
    endfunction

    // ------------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------------
    // reset settings: threshold edge, full hit cycle across the time wrap,
    // phase-end edges, sample ignored on the word that ends retrigger
    task automatic test_default_hit();
        logic [TS_W-1:0] t;
        t = 32'hFFFF_FFF0;
        send_word(SMP_W'(80), t);                   // level 20, not above
        t = t + 5;
        send_word(SMP_W'(-84), t);                  // level 21 starts scan
        send_word(SMP_W'(-512), t + 3000);          // on the edge, still scanning
        t = t + 3001;
        send_word(SMP_W'(0), t);                    // scan over, note event
        send_word(SMP_W'(511), t + 50000);
        t = t + 50001;
        send_word(SMP_W'(511), t);
        send_word(SMP_W'(-512), t + 10000);
        send_word(SMP_W'(-512), t + 10001);         // back to idle, no new hit
        send_word(SMP_W'(-1), t + 10002);
        now_us = t + 10002;
    endtask

    task automatic test_register_extremes();
        logic [TS_W-1:0] t;
        settle_pad();
        load_config(8'h7F, 8'h7F, 8'h7F, 8'h00, 8'h00, 8'h00);
        t = now_us + 100;
        send_word(SMP_W'(511), t);                  // level 127, not above 127
        send_word(SMP_W'(-512), t + 1);             // level 128
        send_word(SMP_W'(0), t + 2);                // full scale not above threshold
        send_word(SMP_W'(0), t + 3);
        send_word(SMP_W'(0), t + 4);
        settle_pad();
        load_config(8'h80, 8'h80, 8'h80, 8'hFF, 8'hFF, 8'hFF);
        t = t + 10;
        send_word(SMP_W'(4), t);                    // level 1 above zero threshold
        send_word(SMP_W'(0), t + 255000);
        t = t + 255001;
        send_word(SMP_W'(0), t);
        t = t + 255001;
        send_word(SMP_W'(0), t);
        t = t + 255001;
        send_word(SMP_W'(0), t);
        settle_pad();
        load_config(8'h00, 8'h7F, 8'h05, 8'h01, 8'h00, 8'h00);
        t = t + 10;
        send_word(SMP_W'(4), t);
        send_word(SMP_W'(0), t + 1001);             // smallest non-zero velocity
        send_word(SMP_W'(0), t + 1002);
        send_word(SMP_W'(0), t + 1003);
        now_us = t + 1003;
    endtask

    // zero-length phases give an event every four words; the sink holds off
    // long enough for the block to back up onto its input
    task automatic test_backpressure();
        int i;
        settle_pad();
        load_config(8'd20, 8'd100, CFG_DAT_W'($urandom_range(0, 127)), 8'h00, 8'h00, 8'h00);
        tx_idle_on = 1'b0;
        rx_hold_cycles = 300;
        for (i = 0; i < 64; i++) begin
            now_us = now_us + 1;
            send_word(SMP_W'(0 - $urandom_range(84, 512)), now_us);
        end
        settle_pad();
        tx_idle_on = 1'b1;
    endtask

    task automatic test_random_play();
        int run;
        int i;
        for (run = 0; run < 40 && words_sent < RANDOM_WORDS; run++) begin
            settle_pad();
            tx_idle_on = ($urandom_range(0, 3) != 0);
            rx_idle_on = ($urandom_range(0, 3) != 0);
            load_config(pick_level(), pick_level(), CFG_DAT_W'($urandom), pick_ms(),
                        pick_ms(), pick_ms());
            for (i = 0; i < WORDS_PER_RUN; i++) begin
                now_us = pick_time(now_us);
                send_word(pick_sample(), now_us);
                words_sent++;
            end
        end
        tx_idle_on = 1'b1;
        rx_idle_on = 1'b1;
    endtask

    initial begin
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_default_hit();
        test_register_extremes();
        test_backpressure();
        test_random_play();
        settle_pad();
        if (mismatch_count == 0) begin
            $display("drum_pad_hit_detector_tb: clean");
        end else begin
            $display("drum_pad_hit_detector_tb: errors");
        end
        $finish;
    end

endmodule
